>>> rtl/owts_pkg.sv
// ----------------------------------------------------------------------------
// owts_pkg
// Types and constants for the one-wire temperature read sequencer.
// ----------------------------------------------------------------------------
package owts_pkg;

  localparam logic [7:0]  ResetByte   = 8'hF0;
  localparam logic [7:0]  SkipRom     = 8'hCC;
  localparam logic [7:0]  ConvertCmd  = 8'h44;
  localparam logic [7:0]  ReadPadCmd  = 8'hBE;
  localparam logic [7:0]  OneSlot     = 8'hFF;
  localparam logic [7:0]  ZeroSlot    = 8'h00;
  localparam logic [15:0] WaitMsReset = 16'd750;
  localparam logic [15:0] WaitMax     = 16'hFFFF;
  localparam logic [3:0]  LastCmdBit  = 4'd7;
  localparam logic [3:0]  LastReadBit = 4'd15;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_ECHO  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_RST1  = 4'd1,
    PH_SKIP1 = 4'd2,
    PH_CONV  = 4'd3,
    PH_WAIT  = 4'd4,
    PH_RST2  = 4'd5,
    PH_SKIP2 = 4'd6,
    PH_RDCMD = 4'd7,
    PH_READ  = 4'd8
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } owts_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        fast_rate;
    logic [15:0] temperature;
  } owts_out_t;

endpackage

>>> rtl/owts_core.sv
// ----------------------------------------------------------------------------
// owts_core
// Sequencer state and the combinational step that turns one item into at
// most one result.
// ----------------------------------------------------------------------------
module owts_core import owts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_valid_i,
  input  owts_in_t    item_i,
  input  logic [15:0] wait_ms_i,
  output logic        res_valid_o,
  output owts_out_t   res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] shift_q, shift_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] temp_q, temp_d;

  logic [3:0]  bit_inc;
  logic [15:0] wait_inc;
  logic [15:0] shift_set;

  assign bit_inc  = bit_q + 4'd1;
  assign wait_inc = (wait_q < WaitMax) ? wait_q + 16'd1 : wait_q;

  always_comb begin
    shift_set         = shift_q;
    shift_set[bit_q]  = 1'b1;
  end

  always_comb begin
    phase_d     = phase_q;
    bit_d       = bit_q;
    cmd_d       = cmd_q;
    shift_d     = shift_q;
    wait_d      = wait_q;
    temp_d      = temp_q;
    res_valid_o = 1'b0;
    res_o.kind      = KIND_TX;
    res_o.tx_byte   = ZeroSlot;
    res_o.fast_rate = 1'b0;

    if (step_valid_i) begin
      if (item_i.mode == MODE_START) begin
        bit_d         = '0;
        shift_d       = '0;
        wait_d        = '0;
        phase_d       = PH_RST1;
        res_valid_o   = 1'b1;
        res_o.tx_byte = ResetByte;
      end else if (item_i.mode == MODE_TICK) begin
        if (phase_q == PH_WAIT) begin
          wait_d = wait_inc;
          if (wait_inc >= wait_ms_i) begin
            phase_d       = PH_RST2;
            res_valid_o   = 1'b1;
            res_o.tx_byte = ResetByte;
          end
        end
      end else if (item_i.mode == MODE_ECHO) begin
        unique case (phase_q)
          PH_RST1, PH_RST2: begin
            res_valid_o = 1'b1;
            if (item_i.rx_byte == ResetByte) begin
              // no presence pulse
              temp_d     = '0;
              phase_d    = PH_IDLE;
              res_o.kind = KIND_FAIL;
            end else begin
              phase_d         = (phase_q == PH_RST1) ? PH_SKIP1 : PH_SKIP2;
              cmd_d           = SkipRom;
              bit_d           = '0;
              res_o.tx_byte   = SkipRom[0] ? OneSlot : ZeroSlot;
              res_o.fast_rate = 1'b1;
            end
          end
          PH_SKIP1, PH_CONV, PH_SKIP2, PH_RDCMD: begin
            if (bit_q < LastCmdBit) begin
              bit_d           = bit_inc;
              res_valid_o     = 1'b1;
              res_o.tx_byte   = cmd_q[bit_inc[2:0]] ? OneSlot : ZeroSlot;
              res_o.fast_rate = 1'b1;
            end else if (phase_q == PH_SKIP1) begin
              phase_d         = PH_CONV;
              cmd_d           = ConvertCmd;
              bit_d           = '0;
              res_valid_o     = 1'b1;
              res_o.tx_byte   = ConvertCmd[0] ? OneSlot : ZeroSlot;
              res_o.fast_rate = 1'b1;
            end else if (phase_q == PH_SKIP2) begin
              phase_d         = PH_RDCMD;
              cmd_d           = ReadPadCmd;
              bit_d           = '0;
              res_valid_o     = 1'b1;
              res_o.tx_byte   = ReadPadCmd[0] ? OneSlot : ZeroSlot;
              res_o.fast_rate = 1'b1;
            end else if (phase_q == PH_CONV) begin
              wait_d = '0;
              if (wait_ms_i == '0) begin
                phase_d       = PH_RST2;
                res_valid_o   = 1'b1;
                res_o.tx_byte = ResetByte;
              end else begin
                phase_d = PH_WAIT;
              end
            end else begin
              phase_d         = PH_READ;
              bit_d           = '0;
              shift_d         = '0;
              res_valid_o     = 1'b1;
              res_o.tx_byte   = OneSlot;
              res_o.fast_rate = 1'b1;
            end
          end
          PH_READ: begin
            res_valid_o = 1'b1;
            if (item_i.rx_byte == OneSlot) begin
              shift_d = shift_set;
            end
            if (bit_q >= LastReadBit) begin
              temp_d     = (item_i.rx_byte == OneSlot) ? shift_set : shift_q;
              phase_d    = PH_IDLE;
              bit_d      = '0;
              res_o.kind = KIND_DONE;
            end else begin
              bit_d           = bit_inc;
              res_o.tx_byte   = OneSlot;
              res_o.fast_rate = 1'b1;
            end
          end
          default: begin
            // idle or waiting: drop the echo
          end
        endcase
      end
    end
    res_o.temperature = temp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= '0;
      cmd_q   <= '0;
      shift_q <= '0;
      wait_q  <= '0;
      temp_q  <= '0;
    end else begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      cmd_q   <= cmd_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      temp_q  <= temp_d;
    end
  end

endmodule

>>> rtl/one_wire_temperature_read_sequencer.sv
// ----------------------------------------------------------------------------
// one_wire_temperature_read_sequencer
// An accepted item is held in the input register; the combinational step
// logic then moves any result into the result register once that register
// has room. Throughput: one item per cycle while the output is not stalled;
// the step logic is combinational between the input register and the result
// register, and a result stall reaches the input stall in the same cycle.
// Reset clears the sequencer state, both valid flags and sets the
// conversion wait to 750 ms.
// ----------------------------------------------------------------------------
module one_wire_temperature_read_sequencer import owts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  owts_in_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output owts_out_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic        in_valid_q;
  owts_in_t    in_item_q;
  logic        out_valid_q;
  owts_out_t   out_item_q;
  logic [15:0] wait_ms_q;

  logic        advance;
  logic        res_valid;
  owts_out_t   res;

  // step the held item once the result register has room
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  owts_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (advance),
    .item_i       (in_item_q),
    .wait_ms_i    (wait_ms_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wait_ms_q   <= WaitMsReset;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= res_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        wait_ms_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
